[sv/lale_pkg.sv]
// Shared types and constants of the LMS adaptive line enhancer.
`timescale 1ns / 1ps

package lale_pkg;

    localparam int SAMPLE_W = 16;   // Q1.15 sample, error and prediction
    localparam int STEP_W   = 16;   // unsigned Q0.16 step size
    localparam int WEIGHT_W = 32;   // signed Q4.28 weight
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 16'd328;

    // register index, taken from paddr above the byte lanes
    localparam logic [APB_AW-3:0] REG_STEP_SIZE = 1'b0;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_LOAD  = 10'b00_0000_0100,
        S_MAC   = 10'b00_0000_1000,
        S_ROUND = 10'b00_0001_0000,
        S_ERR   = 10'b00_0010_0000,
        S_MUE   = 10'b00_0100_0000,
        S_UPD   = 10'b00_1000_0000,
        S_OUT   = 10'b01_0000_0000,
        S_SPARE = 10'b10_0000_0000
    } lale_state_t;

endpackage

[sv/lms_adaptive_line_enhancer.sv]
// Top level of the LMS adaptive line enhancer: sequencer, MAC pipeline and memories.
`timescale 1ns / 1ps

// LMS adaptive line enhancer.
// Input channel: in_valid / in_stall with sample (signed Q1.15). One item is
// taken when in_valid is high and in_stall is low. in_stall stays high while an
// item is being worked on, so items are handled one at a time.
// Output channel: out_valid / out_stall with error_out (sample minus
// prediction, the cleaned signal) and prediction (the periodic component).
// One result item per input item. The result sits in an output register; a
// stalled result holds and the block still takes the next input item. A new
// result is loaded only once the previous one has been taken.
// Timing: one shared MAC pipeline runs a prediction pass and a weight update
// pass over the TAP_COUNT taps, one tap per cycle, reading the weight and tap
// memories. Steps: S_LOAD, the prediction pass (S_MAC), S_ROUND, S_ERR, S_MUE,
// the update pass (S_UPD), then S_OUT, which loads the result and raises
// out_valid once the previous result has been taken, then returns to S_IDLE.
// Reset: after rst_n is released a clearing pass writes zero to all three
// memories, with in_stall high. APB writes to step_size (address 0, reset 328)
// are taken at any time, also during the clearing pass.
module lms_adaptive_line_enhancer #(
    parameter int TAP_COUNT   = 64,
    parameter int DELAY_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [lale_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [lale_pkg::SAMPLE_W-1:0]  error_out,
    output logic signed [lale_pkg::SAMPLE_W-1:0]  prediction,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [lale_pkg::APB_AW-1:0]    paddr,
    input  logic        [lale_pkg::APB_DW-1:0]    pwdata,
    output logic        [lale_pkg::APB_DW-1:0]    prdata,
    output logic                                  pready
);
    import lale_pkg::*;

    localparam int IDX_W     = $clog2(TAP_COUNT);
    localparam int DLY_W     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CLEAR_LEN = (TAP_COUNT > DELAY_DEPTH) ? TAP_COUNT : DELAY_DEPTH;
    localparam int CLR_W     = $clog2(CLEAR_LEN);
    localparam int PROD_W    = WEIGHT_W + SAMPLE_W;      // weight * tap
    localparam int ACC_W     = PROD_W + IDX_W;           // exact sum of all products
    localparam int YW_W      = ACC_W - 28;               // accumulator after >> 28
    localparam int ME_W      = STEP_W + 1 + SAMPLE_W;    // mu * e
    localparam int UPD_W     = ME_W + SAMPLE_W;          // mu * e * tap
    localparam int DELTA_W   = UPD_W - 16;               // after >> 16
    localparam int SUM_W     = WEIGHT_W + 2;

    // ---------------------------------------------------------------- memories
    logic signed [WEIGHT_W-1:0] weight_mem [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] tap_mem    [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] delay_mem  [DELAY_DEPTH];

    logic signed [WEIGHT_W-1:0] w_rdata_reg;
    logic signed [SAMPLE_W-1:0] tap_rdata_reg;
    logic signed [SAMPLE_W-1:0] dly_rdata_reg;

    logic                       w_we, tap_we, dly_we;
    logic        [IDX_W-1:0]    w_waddr, tap_waddr;
    logic        [DLY_W-1:0]    dly_waddr;
    logic signed [WEIGHT_W-1:0] w_wdata;
    logic signed [SAMPLE_W-1:0] tap_wdata;

    // ------------------------------------------------------------ control regs
    lale_state_t          state_reg, state_next;
    logic [CLR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]     tptr_reg, tptr_next;
    logic [DLY_W-1:0]     dptr_reg, dptr_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;       // weight index being issued
    logic [IDX_W-1:0]     idx_reg, idx_next;       // matching tap index
    logic                 issue_reg, issue_next;
    logic                 s1_v_reg, s2_v_reg, s3_v_reg;
    logic                 s1_v_next, s2_v_next, s3_v_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    // ------------------------------------------------------------ payload regs
    logic signed [SAMPLE_W-1:0] x_reg;
    logic        [IDX_W-1:0]    s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic signed [PROD_W-1:0]   mac_prod_reg;
    logic signed [UPD_W-1:0]    upd_prod_reg;
    logic signed [WEIGHT_W-1:0] w_s2_reg, w_s3_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] y_reg, e_reg;
    logic signed [ME_W-1:0]     me_reg;
    logic signed [SAMPLE_W-1:0] err_out_reg, pred_out_reg;

    // ------------------------------------------------------------- datapath
    logic                       clearing, clr_in_taps, clr_in_dly;
    logic                       accept, out_load, pass_done, cfg_write;
    logic signed [PROD_W-1:0]   mac_prod;
    logic signed [UPD_W-1:0]    upd_prod, upd_rnd;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [WEIGHT_W-1:0] w_new;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [YW_W-1:0]     y_wide;
    logic signed [SAMPLE_W-1:0] y_sat, e_sat;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [ME_W-1:0]     me_prod;

    assign clearing    = (state_reg == S_CLEAR);
    assign clr_in_taps = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(TAP_COUNT));
    assign clr_in_dly  = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(DELAY_DEPTH));
    assign accept      = in_valid && !in_stall;
    assign out_load    = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign pass_done   = !issue_reg && !s1_v_reg && !s2_v_reg && !s3_v_reg;
    assign cfg_write   = psel && penable && pwrite && pready
                         && (paddr[APB_AW-1:2] == REG_STEP_SIZE);

    always_comb
    begin
        mac_prod = w_rdata_reg * tap_rdata_reg;
        upd_prod = me_reg * tap_rdata_reg;

        // round half up, then drop 16 fraction bits
        upd_rnd  = upd_prod_reg + UPD_W'(32'sd32768);

        w_sum = SUM_W'(w_s3_reg) + SUM_W'(delta_reg);
        if ((&w_sum[SUM_W-1:WEIGHT_W-1]) || !(|w_sum[SUM_W-1:WEIGHT_W-1]))
        begin
            w_new = w_sum[WEIGHT_W-1:0];
        end
        else
        begin
            w_new = w_sum[SUM_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                   : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end

        acc_rnd = acc_reg + ACC_W'(64'sd134217728);
        y_wide  = acc_rnd[ACC_W-1:28];
        if ((&y_wide[YW_W-1:SAMPLE_W-1]) || !(|y_wide[YW_W-1:SAMPLE_W-1]))
        begin
            y_sat = y_wide[SAMPLE_W-1:0];
        end
        else
        begin
            y_sat = y_wide[YW_W-1] ? 16'sh8000 : 16'sh7FFF;
        end

        diff = {x_reg[SAMPLE_W-1], x_reg} - {y_reg[SAMPLE_W-1], y_reg};
        if (diff[SAMPLE_W] == diff[SAMPLE_W-1])
        begin
            e_sat = diff[SAMPLE_W-1:0];
        end
        else
        begin
            e_sat = diff[SAMPLE_W] ? 16'sh8000 : 16'sh7FFF;
        end

        me_prod = $signed({1'b0, step_reg}) * e_reg;
    end

    // memory port selection: the clearing pass owns every write port
    always_comb
    begin
        w_we      = (clearing && clr_in_taps) || s3_v_reg;
        w_waddr   = clearing ? clr_cnt_reg[IDX_W-1:0] : s3_addr_reg;
        w_wdata   = clearing ? '0 : w_new;
        tap_we    = (clearing && clr_in_taps) || (state_reg == S_LOAD);
        tap_waddr = clearing ? clr_cnt_reg[IDX_W-1:0] : tptr_reg;
        tap_wdata = clearing ? '0 : dly_rdata_reg;
        dly_we    = (clearing && clr_in_dly) || (state_reg == S_LOAD);
        dly_waddr = clearing ? clr_cnt_reg[DLY_W-1:0] : dptr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[w_waddr] <= w_wdata;
        end
        w_rdata_reg <= weight_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_waddr] <= tap_wdata;
        end
        tap_rdata_reg <= tap_mem[idx_reg];
    end

    // the delay line is read at the pointer every cycle; the word read in the
    // accept cycle is the sample leaving the line
    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            delay_mem[dly_waddr] <= clearing ? '0 : x_reg;
        end
        dly_rdata_reg <= delay_mem[dptr_reg];
    end

    // ------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        tptr_next      = tptr_reg;
        dptr_next      = dptr_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        s1_v_next      = issue_reg;
        s2_v_next      = s1_v_reg;
        s3_v_next      = s2_v_reg && (state_reg == S_UPD);
        out_valid_next = out_valid_reg;
        step_next      = cfg_write ? pwdata[STEP_W-1:0] : step_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (issue_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            idx_next = (idx_reg == '0) ? IDX_W'(TAP_COUNT - 1) : idx_reg - 1'b1;
            if (cnt_reg == IDX_W'(TAP_COUNT - 1))
            begin
                issue_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLEAR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                dptr_next  = (dptr_reg == DLY_W'(DELAY_DEPTH - 1)) ? '0 : dptr_reg + 1'b1;
                cnt_next   = '0;
                idx_next   = tptr_reg;
                issue_next = 1'b1;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (pass_done)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                state_next = S_MUE;
            end
            S_MUE:
            begin
                cnt_next   = '0;
                idx_next   = tptr_reg;
                issue_next = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (pass_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    tptr_next  = (tptr_reg == IDX_W'(TAP_COUNT - 1)) ? '0 : tptr_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            tptr_reg      <= '0;
            dptr_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tptr_reg      <= tptr_next;
            dptr_reg      <= dptr_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            issue_reg     <= issue_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            s3_v_reg      <= s3_v_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // pipeline and result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample;
        end
        s1_addr_reg <= cnt_reg;
        s2_addr_reg <= s1_addr_reg;
        s3_addr_reg <= s2_addr_reg;
        if (s1_v_reg)
        begin
            mac_prod_reg <= mac_prod;
            upd_prod_reg <= upd_prod;
            w_s2_reg     <= w_rdata_reg;
        end
        if (s2_v_reg)
        begin
            delta_reg <= upd_rnd[UPD_W-1:16];
            w_s3_reg  <= w_s2_reg;
        end
        if (state_reg == S_LOAD)
        begin
            acc_reg <= '0;
        end
        else if (s2_v_reg && (state_reg == S_MAC))
        begin
            acc_reg <= acc_reg + ACC_W'(mac_prod_reg);
        end
        if (state_reg == S_ROUND)
        begin
            y_reg <= y_sat;
        end
        if (state_reg == S_ERR)
        begin
            e_reg <= e_sat;
        end
        if (state_reg == S_MUE)
        begin
            me_reg <= me_prod;
        end
        if (out_load)
        begin
            err_out_reg  <= e_reg;
            pred_out_reg <= y_reg;
        end
    end

    // ---------------------------------------------------------------- ports
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign error_out  = err_out_reg;
    assign prediction = pred_out_reg;
    assign pready     = 1'b1;

    always_comb
    begin
        if (paddr[APB_AW-1:2] == REG_STEP_SIZE)
        begin
            prdata = {{(APB_DW - STEP_W){1'b0}}, step_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

endmodule

[sv/lale_checker.sv]
// Port-level checker for the LMS adaptive line enhancer, with its bind.
`timescale 1ns / 1ps

module lale_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [lale_pkg::SAMPLE_W-1:0] error_out,
    input logic signed [lale_pkg::SAMPLE_W-1:0] prediction
);
    import lale_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(error_out) && $stable(prediction))
        else $error("stalled result item changed");

    // one item at a time: the input closes right after an item is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after an item was taken");

    // a result never appears in the cycle after an item is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result item appeared too early");

    // clearing pass keeps the input closed right after reset
    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("input open during clearing pass");

endmodule

bind lms_adaptive_line_enhancer lale_checker u_lale_checker (.*);
